// ===== rtl/core/bsk_pkg.sv =====
package bsk_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_POS   = 3'd4;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [7:0]  val;
  } cell_ctl_t;

endpackage

// ===== rtl/core/bsk_cell.sv =====
module bsk_cell
  import bsk_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] key,
  input  logic       occupied,
  input  logic       force_hit,
  input  logic       hit_in,
  input  logic [7:0] up_q,
  input  logic [7:0] dn_q,
  output logic       hit_out,
  output logic [7:0] q
);

  logic [7:0] entry_r;
  logic [7:0] entry_nxt;
  logic       match;

  assign match   = force_hit | (occupied && (entry_r == key));
  assign hit_out = hit_in | match;
  assign q       = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_OPEN: begin
        // below the gap: take the entry from above; at the gap: load the new byte
        if (hit_in) begin
          entry_nxt = up_q;
        end else if (match) begin
          entry_nxt = ctl.val;
        end
      end
      CELL_CLOSE: begin
        if (hit_out) begin
          entry_nxt = dn_q;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/core/byte_stack_with_keyed_insert_delete_top.sv =====
// Channel   Direction  Ports                                              Handshake
// request   in         in_req_type in_item_value in_match_key             start & !busy
//                      in_read_position
// result    out        out_status out_read_byte out_entry_count           out_valid strobe
//
// One request per cycle: a row of DEPTH cells compares every entry with the
// key at once and shifts in the same cycle, so busy stays low.
// The result shows in the cycle after the request is taken, for one cycle only.
// Synchronous active-low reset empties the stack; entry bytes are not cleared.
// The receiver cannot stall the result strobe.
module byte_stack_with_keyed_insert_delete_top
  import bsk_pkg::*;
#(
  parameter int DEPTH = 16
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_item_value,
  input  logic [7:0] in_match_key,
  input  logic [3:0] in_read_position,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_read_byte,
  output logic [4:0] out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RN = (DEPTH < 16) ? DEPTH : 16;

  logic [CW-1:0] count_r, count_nxt;
  logic          valid_r;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    rd_r, rd_nxt;

  cell_ctl_t     ctl;
  logic [7:0]    search_key;
  logic          force_top;
  logic [7:0]    cell_q [DEPTH];
  logic          hit [DEPTH+1];
  logic          accept;
  logic          empty, full, found;
  logic [CW+3:0] pos_x, cnt_x;
  logic [CW+4:0] cnt_out_x;
  logic [7:0]    rd_sel;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CW'(DEPTH));
  assign found  = hit[DEPTH];
  assign hit[0] = 1'b0;
  assign pos_x  = {{CW{1'b0}}, in_read_position};
  assign cnt_x  = {4'b0000, count_r};

  // delete searches for the item byte, insert for the key
  assign search_key = (in_req_type == REQ_DELETE) ? in_item_value : in_match_key;
  // push and pop act at the top whatever it holds
  assign force_top  = (in_req_type == REQ_PUSH) || (in_req_type == REQ_POP);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] up_q, dn_q;
    logic       occ;
    if (i == 0) begin : g_top
      assign up_q = 8'h00;
    end else begin : g_mid
      assign up_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign dn_q = cell_q[i];
    end else begin : g_inner
      assign dn_q = cell_q[i+1];
    end
    assign occ = (count_r > CW'(i));
    bsk_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (search_key),
      .occupied  (occ),
      .force_hit ((i == 0) ? force_top : 1'b0),
      .hit_in    (hit[i]),
      .up_q      (up_q),
      .dn_q      (dn_q),
      .hit_out   (hit[i+1]),
      .q         (cell_q[i])
    );
  end

  // read port: positions only reach the first sixteen entries
  always_comb begin
    rd_sel = 8'h00;
    for (int i = 0; i < RN; i++) begin
      if (in_read_position == 4'(i)) begin
        rd_sel = rd_sel | cell_q[i];
      end
    end
  end

  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.val    = in_item_value;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_nxt     = 8'h00;
    case (in_req_type)
      REQ_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.op    = CELL_OPEN;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.op    = CELL_CLOSE;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_INSERT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          ctl.op    = CELL_OPEN;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_DELETE: begin
        if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          ctl.op    = CELL_CLOSE;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_READ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_nxt = ST_BAD_POS;
        end else begin
          rd_nxt = rd_sel;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    // drop everything unless an item is taken this cycle
    if (!accept) begin
      ctl.op    = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign cnt_out_x       = {5'b00000, count_r};
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_read_byte   = rd_r;
  assign out_entry_count = cnt_out_x[4:0];

endmodule

// ===== rtl/core/bsk_chk.sv =====
module bsk_chk
  import bsk_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [7:0] out_read_byte,
  input logic [4:0] out_entry_count
);

  // every taken item gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("taken item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a taken item");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> $stable(out_entry_count))
    else $error("entry count moved while idle");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_entry_count == $past(out_entry_count)))
    else $error("failed request changed the entry count");

  a_read_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_byte != 8'h00) |-> (out_status == ST_OK))
    else $error("read byte set on a failed request");

endmodule

bind byte_stack_with_keyed_insert_delete_top bsk_chk u_bsk_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_read_byte   (out_read_byte),
  .out_entry_count (out_entry_count)
);
